// ===== src/bbt_pkg.sv =====
package bbt_pkg;

	// Permutation table layout and register widths
	localparam int PERM_SLOTS = 8;
	localparam int ENTRY_W    = 3;
	localparam int BLEN_W     = 4;
	localparam int PERM_W     = PERM_SLOTS * ENTRY_W;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM_TABLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

	// Register reset values: full block, identity permutation, encrypt
	localparam logic [BLEN_W-1:0] BLEN_RESET = 4'd8;
	localparam logic [PERM_W-1:0] PERM_RESET = 24'd16434824;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;    // store the input beat
		logic perm;    // permute the closed block into the result buffer
		logic trim;    // work out how many result beats to send
		logic load;    // push the next result beat into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic close;      // the beat on offer closes the block
		logic out_free;   // output register can take a beat this cycle
		logic emit_last;  // the beat being loaded is the last of the block
	} stat_t;

endpackage

// ===== src/bbt_ctrl.sv =====
module bbt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  bbt_pkg::stat_t stat,
	output bbt_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_PERM,
		ST_TRIM,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Issue commands from the current state
	always_comb begin
		cmd.take = ready_q && s_tvalid;
		cmd.perm = (state_q == ST_PERM);
		cmd.trim = (state_q == ST_TRIM);
		cmd.load = (state_q == ST_EMIT) && stat.out_free;
	end

	assign s_tready = ready_q;

	// Advance the sequencer and hold the input ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (cmd.take && stat.close) begin
						state_q <= ST_PERM;
						ready_q <= 1'b0;
					end
				end
				ST_PERM: begin
					state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free && stat.emit_last) begin
						state_q <= ST_COLLECT;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== src/bbt_datapath.sv =====
module bbt_datapath #(
	parameter int MAX_BLOCK = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [bbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbt_pkg::PERM_W-1:0]     cfg_data,
	input  logic [bbt_pkg::BYTE_W-1:0]     s_tdata,
	input  logic                           s_tlast,
	input  bbt_pkg::cmd_t                  cmd,
	output bbt_pkg::stat_t                 stat,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [bbt_pkg::BYTE_W-1:0]     m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);

	localparam int CAP    = (MAX_BLOCK < bbt_pkg::PERM_SLOTS) ? MAX_BLOCK : bbt_pkg::PERM_SLOTS;
	localparam int IDX_W  = $clog2(CAP);
	localparam int LEN_W  = $clog2(CAP + 1);
	localparam int BLEN_W = bbt_pkg::BLEN_W;
	localparam int ENT_W  = bbt_pkg::ENTRY_W;
	localparam int BYTE_W = bbt_pkg::BYTE_W;

	// Configuration registers
	logic [BLEN_W-1:0]           block_len_q;
	logic [bbt_pkg::PERM_W-1:0]  perm_q;
	logic                        decrypt_q;

	// Gather buffer and block bookkeeping
	logic [BYTE_W-1:0] buf_q [CAP];
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  hold_q;
	logic              eos_q;

	// Result buffer and emission bookkeeping
	logic [BYTE_W-1:0] res_q [CAP];
	logic [LEN_W-1:0]  cnt_q;
	logic              empty_q;
	logic [IDX_W-1:0]  idx_q;

	// Output register
	logic              m_tvalid_q;
	logic [BYTE_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	logic [LEN_W-1:0]  len_c;
	logic [BLEN_W-1:0] len_b;
	logic [BYTE_W-1:0] blk_c [CAP];
	logic [BYTE_W-1:0] res_c [CAP];
	logic [LEN_W-1:0]  n_c;

	// Limit the block length to 1..CAP
	always_comb begin
		if (block_len_q == '0) begin
			len_c = LEN_W'(1);
		end else if (block_len_q > BLEN_W'(CAP)) begin
			len_c = LEN_W'(CAP);
		end else begin
			len_c = LEN_W'(block_len_q);
		end
		len_b = BLEN_W'(len_c);
	end

	// Report block close, output space and last beat
	always_comb begin
		stat.close     = s_tlast || ((BLEN_W'(fill_q) + BLEN_W'(1)) >= len_b);
		stat.out_free  = !m_tvalid_q || m_tready;
		stat.emit_last = empty_q || ((LEN_W'(idx_q) + LEN_W'(1)) == cnt_q);
	end

	// Pad the closed block with zeros beyond the fill and the length
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			if ((BLEN_W'(i) < len_b) && (IDX_W'(i) <= hold_q)) begin
				blk_c[i] = buf_q[i];
			end else begin
				blk_c[i] = '0;
			end
		end
	end

	// Route block bytes to their result slots
	always_comb begin
		logic [ENT_W-1:0] ent;
		ent = '0;
		for (int o = 0; o < CAP; o++) begin
			res_c[o] = '0;
			if (decrypt_q) begin
				// output slot o takes the source that its entry names
				ent = perm_q[o*ENT_W +: ENT_W];
				if ((BLEN_W'(ent) < len_b) && (BLEN_W'(o) < len_b)) begin
					for (int j = 0; j < CAP; j++) begin
						if (ent == ENT_W'(j)) begin
							res_c[o] = blk_c[j];
						end
					end
				end
			end else begin
				// source i goes to its target; the higher source wins a clash
				for (int i = 0; i < CAP; i++) begin
					ent = perm_q[i*ENT_W +: ENT_W];
					if ((BLEN_W'(i) < len_b) && (BLEN_W'(ent) < len_b) &&
					    (ent == ENT_W'(o))) begin
						res_c[o] = blk_c[i];
					end
				end
			end
		end
	end

	// Count result beats: strip trailing zeros of a final decrypted block
	always_comb begin
		n_c = '0;
		for (int o = 0; o < CAP; o++) begin
			if (res_q[o] != '0) begin
				n_c = LEN_W'(o + 1);
			end
		end
		if (!(eos_q && decrypt_q)) begin
			n_c = len_c;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= bbt_pkg::BLEN_RESET;
			perm_q      <= bbt_pkg::PERM_RESET;
			decrypt_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bbt_pkg::CFG_BLOCK_LEN:    block_len_q <= cfg_data[BLEN_W-1:0];
				bbt_pkg::CFG_PERM_TABLE:   perm_q      <= cfg_data;
				bbt_pkg::CFG_DECRYPT_MODE: decrypt_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.take) begin
			if (stat.close) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + IDX_W'(1);
			end
		end
	end

	// Store input beats and the closing state of the block
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			buf_q[fill_q] <= s_tdata;
			if (stat.close) begin
				hold_q <= fill_q;
				eos_q  <= s_tlast;
			end
		end
	end

	// Capture the permuted block, then its beat count
	always_ff @(posedge clk) begin
		if (cmd.perm) begin
			res_q <= res_c;
		end
		if (cmd.trim) begin
			cnt_q   <= n_c;
			empty_q <= (n_c == '0);
			idx_q   <= '0;
		end else if (cmd.load) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Hold the output valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Load the next result beat; an empty final block sends a bare marker
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= empty_q ? '0 : res_q[idx_q];
			m_tuser_q <= !empty_q;
			m_tlast_q <= eos_q && stat.emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== src/byte_block_transposition.sv =====
// Block transposition of a byte stream, L bytes to a block (L = block_len, 1..min(MAX_BLOCK,8)).
// Input beats are taken one per cycle while a block gathers; the closing beat is followed by
// the permute and trim states, then n result beats from the single result buffer.
// The first result beat is loaded into the output register after permute and trim; n = L, or
// fewer for a stripped final block. No new input is taken until the last result beat is loaded.
// arst_n is asynchronous, active low: registers return to block_len 8, identity, encrypt.
module byte_block_transposition #(
	parameter int MAX_BLOCK = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_stream
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast    // last_out
);

	bbt_pkg::cmd_t  cmd;
	bbt_pkg::stat_t stat;

	// Registers take a write in every cycle
	assign cfg_ready = 1'b1;

	bbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbt_datapath #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/bbt_checker.sv =====
module bbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output beat changed while stalled");

	// An empty marker is a zero byte and always ends the stream
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h00))
		else $error("empty marker without last or with data");

	// The final input beat closes the block: input stalls through permute and trim
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
		else $error("input taken while a closed block is processed");

endmodule

bind byte_block_transposition bbt_checker u_bbt_checker (.*);

// ===== verif/tb.sv =====
module tb;

	localparam int MAX_BLK    = 8;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 24;
	localparam logic [bbt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       last;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tlast = 1'b0; // end_of_stream
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] out_byte
	logic        m_tuser;        // [0] byte_valid
	logic        m_tlast;        // last_out

	// Shadow registers and block state of the predictor
	logic [3:0]  blen_r = bbt_pkg::BLEN_RESET;
	logic [23:0] perm_r = bbt_pkg::PERM_RESET;
	logic        dec_r = 1'b0;
	logic [7:0]  held[MAX_BLK];
	int          fill_r = 0;

	out_beat_t   permuted_q[$];
	int          errors = 0;
	int          cycle_cnt = 0;

	// Idle and hold-off controls
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	logic        hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_left = 0;

	byte_block_transposition #(.MAX_BLOCK(MAX_BLK)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_len(logic [3:0] v);
		int l;
		l = int'(v);
		if (l < 1) l = 1;
		if (l > MAX_BLK) l = MAX_BLK;
		return l;
	endfunction

	// Random permutation of the first l positions; the spare entries are junk
	function automatic logic [23:0] make_perm(int l);
		int p[8];
		int j, t;
		logic [23:0] v;
		for (int i = 0; i < 8; i++) p[i] = (i < l) ? i : $urandom_range(0, 7);
		for (int i = l - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = p[i];
			p[i] = p[j];
			p[j] = t;
		end
		for (int i = 0; i < 8; i++) v[3*i +: 3] = p[i][2:0];
		return v;
	endfunction

	// Append one predicted beat at the tail of the queue
	function automatic void queue_beat(out_beat_t b);
		permuted_q.insert(permuted_q.size(), b);
	endfunction

	// Take one input byte into the block and queue the permuted beats it closes
	function automatic void absorb_byte(logic [7:0] d, logic eos);
		int l, n;
		logic [7:0] blk[8];
		logic [7:0] res[8];
		logic [2:0] ent;
		out_beat_t b;
		l = clamp_len(blen_r);
		if (fill_r < MAX_BLK) held[fill_r] = d;
		if (!eos && fill_r + 1 < l) begin
			fill_r = fill_r + 1;
		end else begin
			for (int i = 0; i < 8; i++) begin
				blk[i] = (i < l && i <= fill_r) ? held[i] : 8'h00;
				res[i] = 8'h00;
			end
			for (int i = 0; i < l; i++) begin
				ent = perm_r[3*i +: 3];
				if (dec_r) begin
					res[i] = (ent < l) ? blk[ent] : 8'h00;
				end else if (ent < l) begin
					res[ent] = blk[i];
				end
			end
			fill_r = 0;
			for (int i = 0; i < MAX_BLK; i++) held[i] = 8'h00;
			n = l;
			// Strip trailing zeros from the final block on decrypt
			if (eos && dec_r)
				while (n > 0 && res[n-1] == 8'h00) n--;
			if (n == 0) begin
				b.data = 8'h00;
				b.vld = 1'b0;
				b.last = 1'b1;
				queue_beat(b);
			end
			for (int i = 0; i < n; i++) begin
				b.data = res[i];
				b.vld = 1'b1;
				b.last = eos && (i + 1 == n);
				queue_beat(b);
			end
		end
	endfunction

	// Offer one beat, idling at random beforehand, and hold it until taken
	task automatic send_byte(logic [7:0] d, logic eos);
		while (tx_idle_en && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= eos;
		do @(posedge clk); while (!s_tready);
		absorb_byte(d, eos);
	endtask

	// Drop the input and wait for every queued beat plus the block's settle time
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (permuted_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(logic [bbt_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bbt_pkg::CFG_BLOCK_LEN:    blen_r = val[3:0];
			bbt_pkg::CFG_PERM_TABLE:   perm_r = val;
			bbt_pkg::CFG_DECRYPT_MODE: dec_r = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [3:0] blen, logic [23:0] perm, logic dec);
		wait_idle();
		write_reg(bbt_pkg::CFG_BLOCK_LEN, {20'($urandom), blen});
		write_reg(bbt_pkg::CFG_PERM_TABLE, perm);
		write_reg(bbt_pkg::CFG_DECRYPT_MODE, {23'($urandom), dec});
		cfg_valid <= 1'b0;
	endtask

	// Reset registers: full block, identity, encrypt; a short padded stream
	task automatic test_reset_config();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b1);
	endtask

	// Zero length saturates to one, oversized length to a full block
	task automatic test_length_extremes();
		set_regs(4'd0, 24'h000000, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		// every entry points at the padding, so the whole final block strips away
		set_regs(4'd15, 24'hFFFFFF, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	// Decrypt with a reversal: one full block, then a final block stripped in part
	task automatic test_decrypt_strip();
		set_regs(4'd4, 24'({3'd0, 3'd1, 3'd2, 3'd3}), 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h22, 1'b1);
	endtask

	// Encrypt with a shared target and an out-of-range target
	task automatic test_bad_entries();
		set_regs(4'd3, 24'({3'd7, 3'd2, 3'd2}), 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h99, 1'b1);
	endtask

	// Shrink the block length while bytes are held; the next byte closes it
	task automatic test_mid_block_change();
		set_regs(4'd8, bbt_pkg::PERM_RESET, 1'b0);
		for (int i = 0; i < 5; i++) send_byte(8'(8'h31 + i), 1'b0);
		wait_idle();
		write_reg(bbt_pkg::CFG_BLOCK_LEN, 24'd3);
		write_reg(CFG_UNUSED, 24'($urandom));
		cfg_valid <= 1'b0;
		send_byte(8'hE7, 1'b0);
	endtask

	// Random streams; some phases leave a block open across the next setting
	task automatic test_random_phase(int n_items, bit calm);
		int r, l, sent, slen;
		logic [3:0] blen;
		logic [23:0] perm;
		logic eos, open_end;
		logic [7:0] d;
		r = $urandom_range(0, 9);
		if (r == 0) blen = 4'd0;
		else if (r == 1) blen = 4'($urandom_range(9, 15));
		else blen = 4'($urandom_range(1, 8));
		l = clamp_len(blen);
		perm = ($urandom_range(0, 4) == 0) ? 24'($urandom) : make_perm(l);
		set_regs(blen, perm, 1'($urandom_range(0, 1)));
		tx_idle_en = !calm;
		rx_idle_en = !calm;
		open_end = ($urandom_range(0, 3) == 0);
		sent = 0;
		while (sent < n_items) begin
			slen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 3 * l);
			if (slen > n_items - sent) slen = n_items - sent;
			for (int k = 0; k < slen; k++) begin
				eos = (k == slen - 1) && !(open_end && sent + slen >= n_items);
				d = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom);
				send_byte(d, eos);
			end
			sent += slen;
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Hold the output off while the input keeps offering, so the block stalls
	task automatic test_backpressure();
		set_regs(4'd8, make_perm(8), 1'b0);
		hold_req <= 1'b1;
		for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);
		hold_req <= 1'b0;
	endtask

	// Output ready: long hold-off on request, otherwise random idling
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_LEN;
		end else if (!hold_req) begin
			hold_seen = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_idle_en && $urandom_range(0, 99) < 11);
		end
	end

	// Compare each output beat with the oldest predicted beat
	always @(posedge clk) begin : check_beats
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (permuted_q.size() == 0) begin
				$error("unexpected beat: out_byte %0h byte_valid %0b last_out %0b",
					m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = permuted_q.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %0h, actual %0h", want.data, m_tdata);
					errors++;
				end
				if (m_tuser !== want.vld) begin
					$error("byte_valid: expected %0b, actual %0b", want.vld, m_tuser);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_out: expected %0b, actual %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		while (cycle_cnt < CYCLE_CAP) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAX_BLK; i++) held[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_config();
		test_length_extremes();
		test_decrypt_strip();
		test_bad_entries();
		test_mid_block_change();
		test_backpressure();
		for (int p = 0; p < 9; p++) test_random_phase(38, p == 4);
		wait_idle();
		if (errors == 0 && permuted_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/bbt_pkg.sv
src/bbt_ctrl.sv
src/bbt_datapath.sv
src/byte_block_transposition.sv
src/bbt_checker.sv
verif/tb.sv
